// File: sv/dns_name_label_encoder_defines.svh
// Assertion macros shared by the encoder's checking code.
`ifndef DNS_NAME_LABEL_ENCODER_DEFINES_SVH
`define DNS_NAME_LABEL_ENCODER_DEFINES_SVH

// Check a same-cycle implication, silent while reset is held
`define DNLE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check an implication in the next cycle, silent while reset is held
`define DNLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/dnle_pkg.sv
package dnle_pkg;

    localparam logic [7:0] DOT_CHAR = 8'h2E;
    localparam logic [7:0] NUL_CHAR = 8'h00;

    // Input kind carried in tuser
    localparam logic MODE_CHAR = 1'b0;
    localparam logic MODE_END  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LEN,
        ST_CHAR,
        ST_TERM
    } dnle_state_t;

    // Controller to datapath
    typedef struct packed {
        logic store;      // buffer the accepted character
        logic start;      // flush transaction accepted, capture its kind
        logic load_len;   // load length byte into output register
        logic load_char;  // load buffered character into output register
        logic load_term;  // load zero terminator into output register
        logic advance;    // step the read pointer
        logic clear;      // empty the label buffer
    } dnle_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic in_char;      // presented item is an ordinary character
        logic count_zero;   // label buffer is empty
        logic at_last_char; // read pointer sits on the last buffered character
        logic is_dot;       // flush was caused by a dot
        logic slot_free;    // output register can take a byte this cycle
    } dnle_status_t;

endpackage

// File: sv/dnle_ram.sv
module dnle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 62
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: sv/dnle_ctrl.sv
module dnle_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  dnle_pkg::dnle_status_t stat,
    output dnle_pkg::dnle_cmd_t    cmd,
    output dnle_pkg::dnle_state_t  state
);

    import dnle_pkg::*;

    dnle_state_t state_reg;
    dnle_state_t state_next;

    assign state = state_reg;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    if (stat.in_char)
                    begin
                        cmd.store = 1'b1;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_LEN;
                    end
                end
            end
            ST_LEN:
            begin
                if (stat.slot_free)
                begin
                    cmd.load_len = 1'b1;
                    if (!stat.count_zero)
                    begin
                        state_next = ST_CHAR;
                    end
                    else if (stat.is_dot)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_TERM;
                    end
                end
            end
            ST_CHAR:
            begin
                if (stat.slot_free)
                begin
                    cmd.load_char = 1'b1;
                    cmd.advance   = 1'b1;
                    if (stat.at_last_char)
                    begin
                        if (stat.is_dot)
                        begin
                            cmd.clear  = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_TERM;
                        end
                    end
                end
            end
            ST_TERM:
            begin
                if (stat.slot_free)
                begin
                    cmd.load_term = 1'b1;
                    cmd.clear     = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: sv/dnle_dp.sv
module dnle_dp #(
    parameter int LABEL_MAX = 62
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [7:0]             s_axis_tdata,
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [7:0]             m_axis_tdata,
    output logic                   m_axis_tlast,
    output logic                   m_axis_tuser,
    input  dnle_pkg::dnle_cmd_t    cmd,
    output dnle_pkg::dnle_status_t stat
);

    import dnle_pkg::*;

    localparam int CW = $clog2(LABEL_MAX + 1);
    localparam int AW = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;
    localparam logic [CW-1:0] CNT_MAX = CW'(LABEL_MAX);

    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          ovf_reg;
    logic          ovf_next;
    logic [CW-1:0] rd_ptr_reg;
    logic [CW-1:0] rd_ptr_next;
    logic          is_dot_reg;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [7:0]    out_byte_reg;
    logic          out_last_reg;
    logic          out_trunc_reg;
    logic [7:0]    rd_data;
    logic          wr_en;
    logic          load;

    // Decode the presented item
    assign stat.in_char      = (s_axis_tuser == MODE_CHAR) && (s_axis_tdata != NUL_CHAR)
                               && (s_axis_tdata != DOT_CHAR);
    assign stat.count_zero   = (cnt_reg == '0);
    assign stat.at_last_char = (rd_ptr_reg == cnt_reg - CW'(1));
    assign stat.is_dot       = is_dot_reg;
    assign stat.slot_free    = !out_valid_reg || m_axis_tready;

    assign wr_en = cmd.store && (cnt_reg < CNT_MAX);
    assign load  = cmd.load_len || cmd.load_char || cmd.load_term;

    // Label buffer; read address runs one step ahead of the pointer
    dnle_ram #(
        .WIDTH (8),
        .DEPTH (LABEL_MAX)
    ) u_label_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (s_axis_tdata),
        .raddr (rd_ptr_next[AW-1:0]),
        .rdata (rd_data)
    );

    // Count, overflow and read pointer
    always_comb
    begin
        cnt_next    = cnt_reg;
        ovf_next    = ovf_reg;
        rd_ptr_next = rd_ptr_reg;
        if (cmd.store)
        begin
            if (wr_en)
            begin
                cnt_next = cnt_reg + CW'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        if (cmd.advance)
        begin
            rd_ptr_next = rd_ptr_reg + CW'(1);
        end
        if (cmd.clear)
        begin
            cnt_next    = '0;
            ovf_next    = 1'b0;
            rd_ptr_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            ovf_reg    <= 1'b0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            ovf_reg    <= ovf_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // Capture the kind of flush
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            is_dot_reg <= (s_axis_tuser == MODE_CHAR) && (s_axis_tdata == DOT_CHAR);
        end
    end

    // Output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_len)
        begin
            out_byte_reg  <= 8'(cnt_reg);
            out_last_reg  <= is_dot_reg && (cnt_reg == '0);
            out_trunc_reg <= ovf_reg;
        end
        else if (cmd.load_char)
        begin
            out_byte_reg  <= rd_data;
            out_last_reg  <= is_dot_reg && (rd_ptr_reg == cnt_reg - CW'(1));
            out_trunc_reg <= ovf_reg;
        end
        else if (cmd.load_term)
        begin
            out_byte_reg  <= NUL_CHAR;
            out_last_reg  <= 1'b1;
            out_trunc_reg <= ovf_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_trunc_reg;

endmodule

// File: sv/dns_name_label_encoder.sv
// DNS name label encoder.
// Slave stream: one name character per transaction. tdata[7:0] is the
// character, tuser[0] is the mode (0 character, 1 end of name). A character
// of zero also ends the name; a dot closes the current label.
// Master stream: one encoded byte per transaction. tdata[7:0] is the byte
// (length, label character or zero terminator), tlast marks the final byte
// caused by one input transaction, tuser[0] flags a label that lost
// characters beyond LABEL_MAX.
// Flow: ordinary characters are accepted one per cycle and give no output.
// A dot holding n buffered characters is accepted, then gives the length
// byte and each character in turn; an end adds the terminator after them.
// The flush runs at one byte a cycle while the output register has room,
// fed by the label RAM read port, whose read address is issued ahead of
// the output register. The length byte is loaded into the output register
// from ST_LEN, the state after the flush transaction is accepted.
// Reset: label count, overflow flag, controller and output valid are
// cleared; the label RAM is left as is and needs no clearing pass.
// Stall: a full output register holds its byte while tready is low and the
// flush pauses; characters are accepted whenever no flush is in progress.
`include "dns_name_label_encoder_defines.svh"

module dns_name_label_encoder #(
    parameter int LABEL_MAX = 62
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] ch
    input  logic       s_axis_tuser,   // [0] mode
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast,
    output logic       m_axis_tuser    // [0] truncated
);

    import dnle_pkg::*;

    dnle_cmd_t    cmd;
    dnle_status_t stat;
    dnle_state_t  state;

    // Sequencer
    dnle_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd),
        .state         (state)
    );

    // Label buffer and output register
    dnle_dp #(
        .LABEL_MAX (LABEL_MAX)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cmd           (cmd),
        .stat          (stat)
    );

    // A flush transaction starts the length byte next
    `DNLE_ASSERT_NEXT(a_flush_starts, s_axis_tvalid && s_axis_tready && !stat.in_char, state == ST_LEN, "flush did not start with length byte")

    // No input is taken while a flush is in progress
    `DNLE_ASSERT_NOW(a_no_accept_busy, state != ST_IDLE, !s_axis_tready, "input accepted during flush")

    // The terminator is a zero byte that closes the run
    `DNLE_ASSERT_NEXT(a_term_byte, state == ST_TERM && stat.slot_free, m_axis_tvalid && m_axis_tlast && (m_axis_tdata == 8'h00), "bad terminator byte")

endmodule

// File: sim/dns_name_label_encoder_tb.sv
`timescale 1ns / 1ps

module dns_name_label_encoder_tb;

    import dnle_pkg::*;

    localparam int LABEL_MAX   = 62;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_GOAL = 190;
    localparam int HOLD_AT     = 90;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 16;

    typedef struct {
        logic       mode;
        logic [7:0] ch;
    } name_item_t;

    typedef struct {
        logic [7:0] value;
        logic       last;
        logic       truncated;
    } wire_byte_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] ch
    logic       s_axis_tuser = 1'b0;    // [0] mode
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] out_byte
    logic       m_axis_tlast;
    logic       m_axis_tuser;           // [0] truncated

    // Characters waiting to be offered, and wire bytes still owed by the block
    name_item_t pending_chars[$];
    wire_byte_t wire_bytes_due[$];

    // Predictor copy of the label buffer
    logic [7:0] label_buf [LABEL_MAX];
    int         label_len = 0;
    logic       chars_lost = 1'b0;

    int items_queued = 0;
    int items_accepted = 0;
    int bytes_seen = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    dns_name_label_encoder #(
        .LABEL_MAX (LABEL_MAX)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Idle pattern changes every couple of dozen transactions: none, heavy, light
    function automatic int draw_wait(int seq);
        case ((seq / 24) % 3)
            0: return 0;
            1: return $urandom_range(0, 15);
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
        endcase
    endfunction

    // Work out the wire bytes caused by one accepted character transaction
    task automatic encode_item(logic mode, logic [7:0] ch);
        wire_byte_t wb;
        logic       was_lost;
        begin
            if (mode == MODE_CHAR && ch != NUL_CHAR && ch != DOT_CHAR)
            begin
                // Buffer or drop the character
                if (label_len < LABEL_MAX)
                begin
                    label_buf[label_len] = ch;
                    label_len++;
                end
                else
                    chars_lost = 1'b1;
            end
            else
            begin
                // Flush length byte and the buffered label
                was_lost = chars_lost;
                wb.value = 8'(label_len);
                wb.last = 1'b0;
                wb.truncated = was_lost;
                wire_bytes_due.push_back(wb);
                for (int i = 0; i < label_len; i++)
                begin
                    wb.value = label_buf[i];
                    wire_bytes_due.push_back(wb);
                end
                label_len = 0;
                chars_lost = 1'b0;
                if (mode == MODE_CHAR && ch == DOT_CHAR)
                    wire_bytes_due[$].last = 1'b1;
                else
                begin
                    // End of name: append the zero terminator
                    wb.value = NUL_CHAR;
                    wb.last = 1'b1;
                    wire_bytes_due.push_back(wb);
                end
            end
        end
    endtask

    // Drive character transactions from the pending queue
    always @(posedge clk or negedge rst_n)
    begin : drive_chars
        name_item_t nxt;
        logic       offering;
        int         in_wait;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= 8'h00;
            s_axis_tuser <= MODE_CHAR;
            in_wait = 0;
        end
        else
        begin
            offering = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                encode_item(s_axis_tuser, s_axis_tdata);
                items_accepted++;
                offering = 1'b0;
            end
            if (!offering)
            begin
                if (in_wait > 0)
                begin
                    in_wait--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_chars.size() > 0)
                begin
                    nxt = pending_chars.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= nxt.ch;
                    s_axis_tuser <= nxt.mode;
                    in_wait = draw_wait(items_accepted);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    task automatic check_field(string field, int expected, int actual);
        if (expected != actual)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, expected, actual);
            mismatch_count++;
        end
    endtask

    // Accept wire bytes, compare against the oldest prediction, pace tready
    always @(posedge clk or negedge rst_n)
    begin : collect_bytes
        wire_byte_t exp_byte;
        int         out_wait;
        int         hold_left;
        logic       held_off;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            out_wait = 0;
            hold_left = 0;
            held_off = 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                bytes_seen++;
                if (wire_bytes_due.size() == 0)
                begin
                    $error("unexpected byte 0x%0h with nothing predicted", m_axis_tdata);
                    mismatch_count++;
                end
                else
                begin
                    exp_byte = wire_bytes_due.pop_front();
                    check_field("out_byte", exp_byte.value, m_axis_tdata);
                    check_field("last", exp_byte.last, m_axis_tlast);
                    check_field("truncated", exp_byte.truncated, m_axis_tuser);
                end
                out_wait = draw_wait(bytes_seen + 12);
                // Hold off once for long enough that the input side backs up
                if (bytes_seen == HOLD_AT && !held_off)
                begin
                    held_off = 1'b1;
                    hold_left = HOLD_CYCLES;
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (out_wait > 0)
            begin
                out_wait--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic queue_item(logic mode, logic [7:0] ch);
        name_item_t it;
        begin
            it.mode = mode;
            it.ch = ch;
            pending_chars.push_back(it);
            items_queued++;
        end
    endtask

    function automatic logic [7:0] random_char();
        logic [7:0] v;
        begin
            v = 8'($urandom_range(1, 255));
            if (v == DOT_CHAR)
                v = 8'h2F;
            return v;
        end
    endfunction

    task automatic queue_label(int len);
        for (int i = 0; i < len; i++)
            queue_item(MODE_CHAR, random_char());
    endtask

    initial
    begin : run_test
        int   labels;
        int   len;
        logic first_name;
        first_name = 1'b1;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty name, ignored ch with every bit set
        queue_item(MODE_END, 8'hFF);
        // Character extremes, neighbours of the dot, closed by a dot
        queue_item(MODE_CHAR, 8'h01);
        queue_item(MODE_CHAR, 8'hFF);
        queue_item(MODE_CHAR, 8'h2D);
        queue_item(MODE_CHAR, 8'h2F);
        queue_item(MODE_CHAR, DOT_CHAR);
        // Empty label between two dots
        queue_item(MODE_CHAR, DOT_CHAR);
        // Zero character ends the name
        queue_item(MODE_CHAR, 8'h7F);
        queue_item(MODE_CHAR, NUL_CHAR);
        // Trailing dot gives an extra zero label
        queue_item(MODE_CHAR, 8'h80);
        queue_item(MODE_CHAR, DOT_CHAR);
        queue_item(MODE_END, NUL_CHAR);
        // End transaction carrying a dot still ends the name
        queue_item(MODE_END, DOT_CHAR);
        queue_item(MODE_CHAR, 8'h55);
        queue_item(MODE_CHAR, 8'hAA);
        queue_item(MODE_END, DOT_CHAR);

        // Pause the sender until every predicted byte has arrived
        while (items_accepted != items_queued || wire_bytes_due.size() > 0)
            @(negedge clk);

        // Random names: mostly well formed, some noise
        while (items_queued < RANDOM_GOAL + 16)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 3))
                    queue_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end
            else
            begin
                labels = $urandom_range(1, 4);
                for (int l = 0; l < labels; l++)
                begin
                    if (first_name)
                        len = LABEL_MAX + 1;
                    else if ($urandom_range(0, 39) == 0)
                        len = $urandom_range(LABEL_MAX - 2, LABEL_MAX + 4);
                    else
                        len = $urandom_range(0, 8);
                    first_name = 1'b0;
                    queue_label(len);
                    if (l < labels - 1)
                        queue_item(MODE_CHAR, DOT_CHAR);
                end
                case ($urandom_range(0, 3))
                    0, 1: queue_item(MODE_END, 8'($urandom_range(0, 255)));
                    2: queue_item(MODE_CHAR, NUL_CHAR);
                    default:
                    begin
                        queue_item(MODE_CHAR, DOT_CHAR);
                        queue_item(MODE_END, 8'($urandom_range(0, 255)));
                    end
                endcase
            end
        end

        // Drain: everything accepted, every byte back, then an idle tail of DRAIN_CYCLES
        while (items_accepted != items_queued || wire_bytes_due.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
